### rtl/core/fmbq_pkg.sv
// Shared types, codes and sizes for the front/middle/back queue core.
package fmbq_pkg;

    // Sizes
    localparam int CAPACITY   = 1024;
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 3;
    localparam int ST_W       = 2;
    localparam int OCC_W      = 11;
    localparam int HALF_MIN   = (CAPACITY + 1) / 2;
    localparam int HALF_AW    = (HALF_MIN > 1) ? $clog2(HALF_MIN) : 1;
    localparam int HALF_DEPTH = 1 << HALF_AW;
    localparam int HCNT_W     = HALF_AW + 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [HALF_AW-1:0] t_haddr;
    typedef logic [HCNT_W-1:0]  t_hcnt;
    typedef logic [CNT_W-1:0]   t_count;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_MIDDLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_MIDDLE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_BACK    = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

    // Input and result words
    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] popped_value;
        logic [ST_W-1:0]         status;
        logic [OCC_W-1:0]        occupancy;
    } t_out_word;

    // Which end of which half-ring the main access targets
    typedef enum logic [1:0] {
        LOC_F_FRONT,
        LOC_F_BACK,
        LOC_B_FRONT,
        LOC_B_BACK
    } t_loc;

    // Rebalancing move direction
    typedef enum logic {
        MV_F_TO_B,
        MV_B_TO_F
    } t_move;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MV_RD,
        S_MV_WR,
        S_MAIN,
        S_POP_DATA,
        S_RESULT
    } t_state;

endpackage

### rtl/core/fmbq_ram.sv
// Generic simple dual-port RAM with registered read.
module fmbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/front_middle_back_queue_core.sv
// Top level of the front/middle/back queue: sequencer, half-ring pointers and two RAMs.
//
// The queue is kept as two half-rings: the front half holds floor(n/2) values
// and the back half the rest, each a circular buffer in its own RAM with a
// head pointer and a count. Every end of both halves, and the middle (the
// join of the two halves), is then one RAM access away. A word is taken only
// while the block is idle; each command runs through a small sequencer that
// uses the single write and read port of each RAM, then presents its result
// word until it is taken. A rejected push, an empty pop or an unused code
// goes straight to its result; a push writes its value, first moving one
// value across the halves when needed to keep them balanced; a pop reads
// and captures its value, then makes a rebalancing move if needed. Each move
// costs a RAM read and a RAM write. No clearing pass is needed after reset.
module front_middle_back_queue_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fmbq_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output fmbq_pkg::t_out_word o_data
);
    import fmbq_pkg::*;

    t_state r_state, n_state;
    t_haddr r_f_head, n_f_head;
    t_hcnt  r_f_cnt,  n_f_cnt;
    t_haddr r_b_head, n_b_head;
    t_hcnt  r_b_cnt,  n_b_cnt;
    t_count r_count,  n_count;

    logic signed [VAL_W-1:0] r_value,  n_value;
    logic signed [VAL_W-1:0] r_result, n_result;
    logic [ST_W-1:0]         r_status, n_status;
    t_loc                    r_loc,    n_loc;
    t_move                   r_mv_dir, n_mv_dir;
    logic                    r_move,   n_move;
    logic                    r_is_pop, n_is_pop;
    logic                    n_reject;

    logic                    f_we, b_we, f_re, b_re;
    t_haddr                  f_waddr, b_waddr, f_raddr, b_raddr;
    logic [VAL_W-1:0]        f_wdata, b_wdata, f_rdata, b_rdata;

    logic accept;
    logic even, empty, full;
    t_haddr f_back, b_back;

    assign accept = i_valid && o_ready;
    assign even   = ~r_count[0];
    assign empty  = (r_count == '0);
    assign full   = (r_count == t_count'(CAPACITY));
    assign f_back = r_f_head + t_haddr'(r_f_cnt) - t_haddr'(1);
    assign b_back = r_b_head + t_haddr'(r_b_cnt) - t_haddr'(1);

    // Half-ring storage
    fmbq_ram #(.WIDTH(VAL_W), .DEPTH(HALF_DEPTH)) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    fmbq_ram #(.WIDTH(VAL_W), .DEPTH(HALF_DEPTH)) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (n_reject) begin
                        n_state = S_RESULT;
                    end else if (n_move && !n_is_pop) begin
                        n_state = S_MV_RD;
                    end else begin
                        n_state = S_MAIN;
                    end
                end
            end
            S_MV_RD: begin
                n_state = S_MV_WR;
            end
            S_MV_WR: begin
                n_state = r_is_pop ? S_RESULT : S_MAIN;
            end
            S_MAIN: begin
                n_state = r_is_pop ? S_POP_DATA : S_RESULT;
            end
            S_POP_DATA: begin
                n_state = r_move ? S_MV_RD : S_RESULT;
            end
            S_RESULT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Plan, RAM controls and pointer updates
    always_comb begin
        n_f_head = r_f_head;
        n_f_cnt  = r_f_cnt;
        n_b_head = r_b_head;
        n_b_cnt  = r_b_cnt;
        n_count  = r_count;
        n_value  = r_value;
        n_result = r_result;
        n_status = r_status;
        n_loc    = r_loc;
        n_mv_dir = r_mv_dir;
        n_move   = r_move;
        n_is_pop = r_is_pop;
        n_reject = 1'b0;
        f_we     = 1'b0;
        b_we     = 1'b0;
        f_re     = 1'b0;
        b_re     = 1'b0;
        f_waddr  = r_f_head;
        b_waddr  = r_b_head;
        f_raddr  = r_f_head;
        b_raddr  = r_b_head;
        f_wdata  = r_value;
        b_wdata  = r_value;

        case (r_state)
            S_IDLE: begin
                // Decide where the access goes and whether the halves need a move
                n_value  = i_data.push_value;
                n_result = '0;
                n_status = ST_DONE;
                n_move   = 1'b0;
                n_is_pop = 1'b0;
                n_mv_dir = MV_F_TO_B;
                n_loc    = LOC_B_BACK;
                case (i_data.command)
                    CMD_PUSH_FRONT: begin
                        if (full) begin
                            n_reject = 1'b1;
                            n_status = ST_FULL;
                        end else if (empty) begin
                            n_loc = LOC_B_FRONT;
                        end else begin
                            n_loc    = LOC_F_FRONT;
                            n_move   = even;
                            n_mv_dir = MV_F_TO_B;
                        end
                    end
                    CMD_PUSH_MIDDLE: begin
                        if (full) begin
                            n_reject = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            n_loc = even ? LOC_B_FRONT : LOC_F_BACK;
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (full) begin
                            n_reject = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            n_loc    = LOC_B_BACK;
                            n_move   = ~even;
                            n_mv_dir = MV_B_TO_F;
                        end
                    end
                    CMD_POP_FRONT: begin
                        n_is_pop = 1'b1;
                        if (empty) begin
                            n_reject = 1'b1;
                            n_status = ST_EMPTY;
                            n_result = EMPTY_VALUE;
                        end else if (r_f_cnt == '0) begin
                            n_loc = LOC_B_FRONT;
                        end else begin
                            n_loc    = LOC_F_FRONT;
                            n_move   = ~even;
                            n_mv_dir = MV_B_TO_F;
                        end
                    end
                    CMD_POP_MIDDLE: begin
                        n_is_pop = 1'b1;
                        if (empty) begin
                            n_reject = 1'b1;
                            n_status = ST_EMPTY;
                            n_result = EMPTY_VALUE;
                        end else begin
                            n_loc = even ? LOC_F_BACK : LOC_B_FRONT;
                        end
                    end
                    CMD_POP_BACK: begin
                        n_is_pop = 1'b1;
                        if (empty) begin
                            n_reject = 1'b1;
                            n_status = ST_EMPTY;
                            n_result = EMPTY_VALUE;
                        end else begin
                            n_loc    = LOC_B_BACK;
                            n_move   = even;
                            n_mv_dir = MV_F_TO_B;
                        end
                    end
                    default: begin
                        n_reject = 1'b1;
                    end
                endcase
            end

            S_MV_RD: begin
                // Read the value that crosses between the halves
                if (r_mv_dir == MV_F_TO_B) begin
                    f_re    = 1'b1;
                    f_raddr = f_back;
                end else begin
                    b_re    = 1'b1;
                    b_raddr = r_b_head;
                end
            end

            S_MV_WR: begin
                // Write it to the other half and advance both rings
                if (r_mv_dir == MV_F_TO_B) begin
                    b_we     = 1'b1;
                    b_waddr  = r_b_head - t_haddr'(1);
                    b_wdata  = f_rdata;
                    n_b_head = r_b_head - t_haddr'(1);
                    n_b_cnt  = r_b_cnt + t_hcnt'(1);
                    n_f_cnt  = r_f_cnt - t_hcnt'(1);
                end else begin
                    f_we     = 1'b1;
                    f_waddr  = r_f_head + t_haddr'(r_f_cnt);
                    f_wdata  = b_rdata;
                    n_f_cnt  = r_f_cnt + t_hcnt'(1);
                    n_b_head = r_b_head + t_haddr'(1);
                    n_b_cnt  = r_b_cnt - t_hcnt'(1);
                end
            end

            S_MAIN: begin
                // Insert or remove at the chosen end
                if (r_is_pop) begin
                    n_count = r_count - t_count'(1);
                    case (r_loc)
                        LOC_F_FRONT: begin
                            f_re     = 1'b1;
                            f_raddr  = r_f_head;
                            n_f_head = r_f_head + t_haddr'(1);
                            n_f_cnt  = r_f_cnt - t_hcnt'(1);
                        end
                        LOC_F_BACK: begin
                            f_re    = 1'b1;
                            f_raddr = f_back;
                            n_f_cnt = r_f_cnt - t_hcnt'(1);
                        end
                        LOC_B_FRONT: begin
                            b_re     = 1'b1;
                            b_raddr  = r_b_head;
                            n_b_head = r_b_head + t_haddr'(1);
                            n_b_cnt  = r_b_cnt - t_hcnt'(1);
                        end
                        default: begin
                            b_re    = 1'b1;
                            b_raddr = b_back;
                            n_b_cnt = r_b_cnt - t_hcnt'(1);
                        end
                    endcase
                end else begin
                    n_count = r_count + t_count'(1);
                    case (r_loc)
                        LOC_F_FRONT: begin
                            f_we     = 1'b1;
                            f_waddr  = r_f_head - t_haddr'(1);
                            n_f_head = r_f_head - t_haddr'(1);
                            n_f_cnt  = r_f_cnt + t_hcnt'(1);
                        end
                        LOC_F_BACK: begin
                            f_we    = 1'b1;
                            f_waddr = r_f_head + t_haddr'(r_f_cnt);
                            n_f_cnt = r_f_cnt + t_hcnt'(1);
                        end
                        LOC_B_FRONT: begin
                            b_we     = 1'b1;
                            b_waddr  = r_b_head - t_haddr'(1);
                            n_b_head = r_b_head - t_haddr'(1);
                            n_b_cnt  = r_b_cnt + t_hcnt'(1);
                        end
                        default: begin
                            b_we    = 1'b1;
                            b_waddr = r_b_head + t_haddr'(r_b_cnt);
                            n_b_cnt = r_b_cnt + t_hcnt'(1);
                        end
                    endcase
                end
            end

            S_POP_DATA: begin
                // Capture the removed value
                if (r_loc == LOC_F_FRONT || r_loc == LOC_F_BACK) begin
                    n_result = f_rdata;
                end else begin
                    n_result = b_rdata;
                end
            end

            default: begin
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_f_head <= '0;
            r_f_cnt  <= '0;
            r_b_head <= '0;
            r_b_cnt  <= '0;
            r_count  <= '0;
            r_move   <= 1'b0;
            r_is_pop <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_f_head <= n_f_head;
            r_f_cnt  <= n_f_cnt;
            r_b_head <= n_b_head;
            r_b_cnt  <= n_b_cnt;
            r_count  <= n_count;
            r_move   <= n_move;
            r_is_pop <= n_is_pop;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_result <= n_result;
        r_status <= n_status;
        r_loc    <= n_loc;
        r_mv_dir <= n_mv_dir;
    end

    // Handshake and result word
    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = (r_state == S_RESULT);
    assign o_data.popped_value = r_result;
    assign o_data.status       = r_status;
    assign o_data.occupancy    = OCC_W'(r_count);

endmodule
